### rtl/smt_pkg.sv
// Package for the softmax with temperature unit: constants, exponential tables,
// back-end state type and the front-to-back control struct. No dependencies.
package smt_pkg;

  localparam int unsigned DefMaxElements = 64;
  localparam logic [15:0] InvTempReset = 16'd4096;
  localparam int unsigned ExpIntLimit = 12;

  typedef enum logic [2:0] {
    BeIdle,
    BeExpA,
    BeExpB,
    BeExpC,
    BeDiv,
    BeOut
  } be_state_e;

  // Item handed from the front end to the back end.
  typedef struct packed {
    logic        close;
    logic [6:0]  count;
    logic [15:0] max_val;
  } fe_req_t;

  function automatic logic [15:0] exp_int_tab(input logic [3:0] n);
    logic [15:0] r;
    case (n)
      4'd0: r = 16'd0;      // 65536 handled as one by the caller
      4'd1: r = 16'd24109;
      4'd2: r = 16'd8869;
      4'd3: r = 16'd3263;
      4'd4: r = 16'd1200;
      4'd5: r = 16'd442;
      4'd6: r = 16'd162;
      4'd7: r = 16'd60;
      4'd8: r = 16'd22;
      4'd9: r = 16'd8;
      4'd10: r = 16'd3;
      4'd11: r = 16'd1;
      default: r = 16'd0;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] exp_hi_tab(input logic [3:0] n);
    logic [16:0] r;
    case (n)
      4'd0: r = 17'd65536;
      4'd1: r = 17'd61565;
      4'd2: r = 17'd57835;
      4'd3: r = 17'd54331;
      4'd4: r = 17'd51039;
      4'd5: r = 17'd47947;
      4'd6: r = 17'd45042;
      4'd7: r = 17'd42313;
      4'd8: r = 17'd39750;
      4'd9: r = 17'd37341;
      4'd10: r = 17'd35079;
      4'd11: r = 17'd32954;
      4'd12: r = 17'd30957;
      4'd13: r = 17'd29081;
      4'd14: r = 17'd27319;
      default: r = 17'd25664;
    endcase
    return r;
  endfunction

  function automatic logic [16:0] exp_lo_tab(input logic [3:0] n);
    logic [16:0] r;
    case (n)
      4'd0: r = 17'd65536;
      4'd1: r = 17'd65280;
      4'd2: r = 17'd65026;
      4'd3: r = 17'd64772;
      4'd4: r = 17'd64520;
      4'd5: r = 17'd64268;
      4'd6: r = 17'd64018;
      4'd7: r = 17'd63768;
      4'd8: r = 17'd63520;
      4'd9: r = 17'd63272;
      4'd10: r = 17'd63025;
      4'd11: r = 17'd62780;
      4'd12: r = 17'd62535;
      4'd13: r = 17'd62291;
      4'd14: r = 17'd62048;
      default: r = 17'd61806;
    endcase
    return r;
  endfunction

endpackage

### rtl/smt_front.sv
// Front end: scales each logit by the inverse temperature, tracks the
// maximum and the count, and posts a close request. Uses smt_pkg.
module smt_front import smt_pkg::*; #(
  parameter int unsigned MaxElements = DefMaxElements
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  output logic        full_o,
  input  logic [15:0] logit_i,
  input  logic        last_in_i,
  input  logic [15:0] inv_temp_i,
  output logic        wr_en_o,
  output logic [5:0]  wr_addr_o,
  output logic [15:0] wr_data_o,
  output logic        req_valid_o,
  output fe_req_t     req_o,
  input  logic        req_ready_i
);

  logic [15:0] max_q, max_d;
  logic [6:0]  cnt_q, cnt_d;
  logic        mul_vld_q;
  logic        mul_last_q;
  logic signed [32:0] prod_q;
  logic signed [32:0] rnd;
  logic signed [20:0] q;
  logic [15:0] sat;
  logic        room;
  logic        take;

  // One request slot toward the back end. The store belongs to the back end
  // from a close request until its pass has ended.
  assign full_o = req_valid_o || mul_vld_q || !req_ready_i;
  assign take = push_i && !full_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mul_vld_q <= 1'b0;
    end else begin
      mul_vld_q <= take;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      prod_q <= $signed(logit_i) * $signed({1'b0, inv_temp_i});
      mul_last_q <= last_in_i;
    end
  end

  assign rnd = prod_q + 33'sd2048;
  assign q = rnd[32:12];
  always_comb begin
    if (q > 21'sd32767) sat = 16'h7fff;
    else if (q < -21'sd32768) sat = 16'h8000;
    else sat = q[15:0];
  end

  assign room = cnt_q < 7'(MaxElements);
  assign wr_en_o = mul_vld_q && room;
  assign wr_addr_o = cnt_q[5:0];
  assign wr_data_o = sat;

  always_comb begin
    max_d = max_q;
    cnt_d = cnt_q;
    if (wr_en_o) begin
      if ($signed(sat) > $signed(max_q)) max_d = sat;
      cnt_d = cnt_q + 7'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= 16'h8000;
      cnt_q <= '0;
      req_valid_o <= 1'b0;
      req_o <= '0;
    end else begin
      if (req_valid_o && req_ready_i) req_valid_o <= 1'b0;
      if (mul_vld_q && mul_last_q) begin
        req_valid_o <= 1'b1;
        req_o.close <= 1'b1;
        req_o.count <= cnt_d;
        req_o.max_val <= max_d;
        max_q <= 16'h8000;
        cnt_q <= '0;
      end else begin
        max_q <= max_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule

### rtl/smt_div.sv
// Restoring divider, one quotient bit per cycle, for the normalization step.
// No dependencies.
module smt_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [33:0] num_i,
  input  logic [22:0] den_i,
  output logic        done_o,
  output logic [33:0] quo_o
);

  logic [5:0]  cnt_q;
  logic        busy_q;
  logic [33:0] quo_q;
  logic [22:0] rem_q;
  logic [22:0] den_q;
  logic [23:0] trial;
  logic [23:0] diff;

  assign trial = {rem_q, quo_q[33]};
  assign diff = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      cnt_q <= '0;
      done_o <= 1'b0;
    end else begin
      done_o <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q <= 6'd34;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 6'd1;
        if (cnt_q == 6'd1) begin
          busy_q <= 1'b0;
          done_o <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_q) begin
      if (trial >= {1'b0, den_q}) begin
        rem_q <= diff[22:0];
        quo_q <= {quo_q[32:0], 1'b1};
      end else begin
        rem_q <= trial[22:0];
        quo_q <= {quo_q[32:0], 1'b0};
      end
    end
  end

  assign quo_o = quo_q;

endmodule

### rtl/smt_back.sv
// Back end: exponential pass over the store with sum, then a divide pass that
// fills the result slot. Uses smt_pkg and smt_div.
module smt_back import smt_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        req_valid_i,
  input  fe_req_t     req_i,
  output logic        req_ready_o,
  input  logic        fe_wr_i,
  input  logic [5:0]  fe_addr_i,
  input  logic [15:0] fe_data_i,
  output logic        empty_o,
  input  logic        pop_i,
  output logic [15:0] probability_o,
  output logic        last_out_o
);

  logic [16:0] store_q [64];
  logic [16:0] rd_q;
  logic [5:0]  rd_addr;
  logic        be_wr;
  logic [16:0] be_wdata;

  be_state_e   st_q, st_d;
  logic [6:0]  idx_q, idx_d;
  logic [6:0]  cnt_q;
  logic [15:0] max_q;
  logic [22:0] sum_q, sum_d;
  logic [16:0] e1_q;
  logic [15:0] dd_q;
  logic        zero_q;
  logic [33:0] p1;
  logic [33:0] p2;
  logic        dstart_q;
  logic        div_start;
  logic        div_done;
  logic [33:0] quo;
  logic        out_vld_q;
  logic [15:0] prob_q;
  logic        plast_q;
  logic [15:0] d;

  always_ff @(posedge clk_i) begin
    if (fe_wr_i) store_q[fe_addr_i] <= {fe_data_i[15], fe_data_i};
    else if (be_wr) store_q[idx_q[5:0] - 6'd1] <= be_wdata;
    rd_q <= store_q[rd_addr];
  end

  assign req_ready_o = (st_q == BeIdle);
  assign d = max_q - rd_q[15:0];
  // exp(-integer part) is one for a zero integer part.
  assign p1 = (dd_q[11:8] == 4'd0) ? {17'd0, exp_hi_tab(dd_q[7:4])}
            : ({18'd0, exp_int_tab(dd_q[11:8])} * {17'd0, exp_hi_tab(dd_q[7:4])}
               + 34'd32768) >> 16;
  assign p2 = ({17'd0, e1_q} * {17'd0, exp_lo_tab(dd_q[3:0])} + 34'd32768) >> 16;
  assign be_wr = (st_q == BeExpC);
  assign be_wdata = zero_q ? 17'd0 : p2[16:0];
  // The divide starts on the first odd cycle, once the read data has arrived.
  assign div_start = dstart_q && (sum_q != 23'd0);

  smt_div u_div (
    .clk_i,
    .rst_ni,
    .start_i(div_start),
    .num_i  ({1'b0, rd_q, 16'd0} + {12'd0, sum_q[22:1]}),
    .den_i  (sum_q),
    .done_o (div_done),
    .quo_o  (quo)
  );

  always_comb begin
    st_d = st_q;
    idx_d = idx_q;
    sum_d = sum_q;
    rd_addr = idx_q[5:0];
    case (st_q)
      BeIdle: begin
        rd_addr = '0;
        if (req_valid_i) begin
          st_d = (req_i.count == 7'd0) ? BeIdle : BeExpA;
          idx_d = '0;
          sum_d = '0;
        end
      end
      BeExpA: begin
        st_d = BeExpB;
      end
      BeExpB: begin
        st_d = BeExpC;
        idx_d = idx_q + 7'd1;
      end
      BeExpC: begin
        sum_d = sum_q + {6'd0, be_wdata};
        if (idx_q == cnt_q) begin
          st_d = BeDiv;
          idx_d = '0;
        end else begin
          st_d = BeExpA;
        end
      end
      BeDiv: begin
        // Even phase: issue the read; odd phase: divide the read data and wait.
        rd_addr = idx_q[6:1];
        if (idx_q[0] == 1'b0) idx_d = idx_q + 7'd1;
        else if (div_done || (sum_q == 23'd0)) st_d = BeOut;
      end
      BeOut: begin
        rd_addr = idx_q[6:1] + 6'd1;
        if (!out_vld_q) begin
          idx_d = idx_q + 7'd1;
          st_d = (idx_q[6:1] + 6'd1 == cnt_q[5:0] || idx_q[6:1] == 6'd63)
                 ? BeIdle : BeDiv;
        end
      end
      default: st_d = BeIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= BeIdle;
      idx_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
      max_q <= '0;
      out_vld_q <= 1'b0;
      dstart_q <= 1'b0;
    end else begin
      st_q <= st_d;
      idx_q <= idx_d;
      sum_q <= sum_d;
      dstart_q <= (st_q == BeDiv) && (idx_q[0] == 1'b0);
      if (st_q == BeIdle && req_valid_i) begin
        cnt_q <= req_i.count;
        max_q <= req_i.max_val;
      end
      if (pop_i && out_vld_q) out_vld_q <= 1'b0;
      if (st_q == BeOut && !out_vld_q) out_vld_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (st_q == BeExpA) begin
      dd_q <= d;
      zero_q <= (d[15:8] >= 8'(ExpIntLimit));
    end
    if (st_q == BeExpB) e1_q <= p1[16:0];
    if (st_q == BeOut && !out_vld_q) begin
      if (sum_q == 23'd0) prob_q <= 16'd0;
      else if (quo > 34'd65535) prob_q <= 16'hffff;
      else prob_q <= quo[15:0];
      plast_q <= (idx_q[6:1] + 6'd1 == cnt_q[5:0]) || (idx_q[6:1] == 6'd63);
    end
  end

  assign empty_o = !out_vld_q;
  assign probability_o = prob_q;
  assign last_out_o = plast_q;

endmodule

### rtl/softmax_with_temperature_unit.sv
// Softmax with temperature unit, top level: config port, front end, back end.
// Uses smt_pkg, smt_front and smt_back.
//
// Usage: push logits (signed Q8.8) with last_in_i on the final element while
// full is low. Each logit is scaled by the inverse temperature register
// (APB offset 0, Q4.12, reset 1.0) and stored, up to MaxElements entries.
// After the closing element the back end walks the store: for each element
// the states ExpA, ExpB and ExpC compute the exponential and add it to the
// sum; then, for normalization of each element, a read, a start cycle, 34
// divide steps, a done cycle and a load into the result register. The
// serial divider dominates the pass. Results come out in arrival order
// through a one-entry queue (empty/pop), last_out_o on the final one. Input
// is held off with full while an element is being scaled and from the close
// until the back end has loaded its last result.
// A stalled receiver holds the divider pass until its result is popped.
// Reset clears all control state; the store contents are undefined.
module softmax_with_temperature_unit import smt_pkg::*; #(
  parameter int unsigned MaxElements = DefMaxElements
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [0:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        push,
  output logic        full,
  input  logic [15:0] logit_i,
  input  logic        last_in_i,
  output logic        empty,
  input  logic        pop,
  output logic [15:0] probability_o,
  output logic        last_out_o
);

  logic [15:0] inv_temp_q;
  logic        wr_en;
  logic [5:0]  wr_addr;
  logic [15:0] wr_data;
  logic        req_valid;
  fe_req_t     req;
  logic        req_ready;

  assign pready = 1'b1;
  // Only byte offset zero holds a register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) inv_temp_q <= InvTempReset;
    else if (psel && penable && pwrite && paddr == 1'b0) inv_temp_q <= pwdata[15:0];
  end
  assign prdata = (paddr == 1'b0) ? {16'd0, inv_temp_q} : 32'd0;

  smt_front #(.MaxElements(MaxElements)) u_front (
    .clk_i, .rst_ni,
    .push_i(push), .full_o(full), .logit_i, .last_in_i,
    .inv_temp_i(inv_temp_q),
    .wr_en_o(wr_en), .wr_addr_o(wr_addr), .wr_data_o(wr_data),
    .req_valid_o(req_valid), .req_o(req), .req_ready_i(req_ready)
  );

  smt_back u_back (
    .clk_i, .rst_ni,
    .req_valid_i(req_valid), .req_i(req), .req_ready_o(req_ready),
    .fe_wr_i(wr_en), .fe_addr_i(wr_addr), .fe_data_i(wr_data),
    .empty_o(empty), .pop_i(pop), .probability_o, .last_out_o
  );

`ifndef ASSERT_OFF
  a_req_close: assert property (@(posedge clk_i) disable iff (!rst_ni)
    req_valid |-> req.count <= 7'(MaxElements)) else $error("count overflow");
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !pop) |=> $stable(probability_o)) else $error("result changed");
`endif

endmodule
